>>> sv/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // neighbor counts of the life rule
  localparam logic [3:0] SURVIVE_MIN = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  // what one accepted input releases, plus the next states of the
  // four window positions (index {row_sel, col_sel})
  typedef struct packed {
    logic       prev_row;
    logic       last_row;
    logic       prev_col;
    logic       last_col;
    logic [3:0] next_state;
  } lgs_rel_t;

endpackage

>>> sv/lgs_ram.sv
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lgs_col_cell.sv
// ----------------------------------------------------------------------------
// lgs_col_cell
// One column of the 3x3 window; loads its input column, or zeros when zero
// is set, on every accepted transaction.
// ----------------------------------------------------------------------------
module lgs_col_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       clr,
  input  logic       shift,
  input  logic       zero,
  input  logic [2:0] d,
  output logic [2:0] q,
  output logic [2:0] q_next
);

  assign q_next = zero ? 3'b000 : d;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      q <= 3'b000;
    end else if (shift) begin
      q <= q_next;
    end
  end

endmodule

>>> sv/lgs_release.sv
// ----------------------------------------------------------------------------
// lgs_release
// Holds the results released by one input and sends them out one per
// clock through an output register, pausing while out_stall holds it.
// ----------------------------------------------------------------------------
module lgs_release #(
  parameter int AW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lgs_pkg::lgs_rel_t info,
  input  logic [AW-1:0]    row,
  input  logic [AW-1:0]    col,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             next_alive,
  output logic [7:0]       out_row,
  output logic [7:0]       out_col,
  output logic             frame_last,
  output logic             run_last
);

  logic              pend;
  lgs_pkg::lgs_rel_t pinfo;
  logic [AW-1:0]     prow;
  logic [AW-1:0]     pcol;
  logic              row_sel;
  logic              col_sel;

  logic          out_free;
  logic          emit;
  logic          can_col;
  logic          can_row;
  logic          final_res;
  logic [AW-1:0] sel_row;
  logic [AW-1:0] sel_col;

  assign out_free  = !out_valid || !out_stall;
  assign emit      = pend && out_free;
  assign can_col   = !col_sel && pinfo.last_col;
  assign can_row   = !row_sel && pinfo.last_row;
  assign final_res = !can_col && !can_row;
  assign ready     = !pend || (emit && final_res);
  assign sel_row   = row_sel ? prow : prow - 1'b1;
  assign sel_col   = col_sel ? pcol : pcol - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pend <= 1'b1;
      end else if (emit && final_res) begin
        pend <= 1'b0;
      end
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pinfo   <= info;
      prow    <= row;
      pcol    <= col;
      row_sel <= !info.prev_row;
      col_sel <= !info.prev_col;
    end else if (emit) begin
      if (can_col) begin
        col_sel <= 1'b1;
      end else if (can_row) begin
        row_sel <= 1'b1;
        col_sel <= !pinfo.prev_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      next_alive <= pinfo.next_state[{row_sel, col_sel}];
      out_row    <= 8'(sel_row);
      out_col    <= 8'(sel_col);
      frame_last <= row_sel && col_sel;
      run_last   <= final_res;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!pend || (emit && final_res)))
    else $error("pending run overwritten");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("gap inside a run of results");
`endif

endmodule

>>> sv/life_generation_stencil.sv
// ----------------------------------------------------------------------------
// life_generation_stencil
// One Conway Life generation over a square grid streamed in raster order.
// ----------------------------------------------------------------------------
// Cells enter one per clock in raster order while in_stall is low, and each
// result carries its row and column; cells outside the grid are dead, nothing
// wraps. Results lag the input by one row and one column: cell (r-1, c-1)
// leaves after cell (r, c) arrives, through a release register and an output
// register. The output port moves one result per clock while out_stall is
// low, and that port sets the rate: one cell per clock, except that the last
// cell of each row after the first releases two results and holds off the
// next cell until its last result is sent; in the last row every cell after
// the first releases two as well, and the final cell of the frame releases
// four. Writing grid_size (0 reads as 1, values above the grid capacity
// saturate) restarts the frame; write it only while no transaction is in
// flight. The line store holds two rows and needs no clearing after reset.
module life_generation_stencil #(
  parameter int MAX_GRID = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cell_alive,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       next_alive,
  output logic [7:0] out_row,
  output logic [7:0] out_col,
  output logic       frame_last,
  output logic       run_last
);

  localparam int         CAP  = (MAX_GRID < 256) ? MAX_GRID : 256;
  localparam int         AW   = $clog2(CAP);
  localparam logic [8:0] CAP9 = 9'(CAP);

  function automatic logic life_rule(input logic [8:0] win, input int k, input int m);
    logic [15:0] pad;
    logic [3:0]  cnt;
    pad = '0;
    cnt = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        pad[c*4+r] = win[c*3+r];
      end
    end
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        if (!(dc == 1 && dr == 1)) begin
          cnt = cnt + {3'b000, pad[(k-1+dc)*4+(m-1+dr)]};
        end
      end
    end
    if (pad[k*4+m]) begin
      return (cnt == lgs_pkg::SURVIVE_MIN) || (cnt == lgs_pkg::BIRTH_COUNT);
    end
    return cnt == lgs_pkg::BIRTH_COUNT;
  endfunction

  logic [AW-1:0] last_idx;
  logic [AW-1:0] in_row;
  logic [AW-1:0] in_col;

  logic              accept;
  logic              ready;
  logic              c_is_last;
  logic              r_is_last;
  logic              col_first;
  logic [AW-1:0]     col_next;
  logic [AW-1:0]     row_next;
  logic [AW-1:0]     cfg_last;
  logic [AW-1:0]     rd_addr;
  logic [1:0]        rd_data;
  logic              older_m;
  logic              prior_m;
  logic [2:0]        newcol;
  logic [2:0]        col_q    [3];
  logic [2:0]        col_n    [3];
  logic [2:0]        cell_d   [3];
  logic              cell_zero[3];
  logic [8:0]        win_next;
  lgs_pkg::lgs_rel_t info;
  logic              load;

  assign in_stall  = rst || !ready;
  assign accept    = in_valid && !in_stall;
  assign c_is_last = (in_col == last_idx);
  assign r_is_last = (in_row == last_idx);
  assign col_first = (in_col == '0);
  assign col_next  = c_is_last ? '0 : AW'(in_col + 1'b1);
  assign row_next  = !c_is_last ? in_row : (r_is_last ? '0 : AW'(in_row + 1'b1));

  always_comb begin
    priority if (cfg_wr_data == 9'd0) begin
      cfg_last = '0;
    end else if (cfg_wr_data > CAP9) begin
      cfg_last = AW'(CAP - 1);
    end else begin
      cfg_last = AW'(cfg_wr_data - 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx <= AW'(CAP - 1);
      in_row   <= '0;
      in_col   <= '0;
    end else if (cfg_wr_en) begin
      last_idx <= cfg_last;
      in_row   <= '0;
      in_col   <= '0;
    end else if (accept) begin
      in_row <= row_next;
      in_col <= col_next;
    end
  end

  // read one column ahead so the store data is ready when the cell arrives
  always_comb begin
    priority if (rst || cfg_wr_en) begin
      rd_addr = '0;
    end else if (accept) begin
      rd_addr = col_next;
    end else begin
      rd_addr = in_col;
    end
  end

  // bit 1 holds row r-2, bit 0 row r-1
  lgs_ram #(
    .WIDTH(2),
    .DEPTH(CAP)
  ) u_line_store (
    .clk  (clk),
    .we   (accept),
    .waddr(in_col),
    .wdata({prior_m, cell_alive}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign older_m = (in_row > AW'(1)) && rd_data[1];
  assign prior_m = (in_row != '0) && rd_data[0];
  assign newcol  = {cell_alive, prior_m, older_m};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cell_d[i]    = col_q[i+1];
      cell_zero[i] = col_first;
    end
    cell_d[2]    = newcol;
    cell_zero[2] = 1'b0;
  end

  for (genvar g = 0; g < 3; g++) begin : g_window
    lgs_col_cell u_col (
      .clk   (clk),
      .rst   (rst),
      .clr   (cfg_wr_en),
      .shift (accept),
      .zero  (cell_zero[g]),
      .d     (cell_d[g]),
      .q     (col_q[g]),
      .q_next(col_n[g])
    );
  end

  assign win_next = {col_n[2], col_n[1], col_n[0]};

  always_comb begin
    info.prev_row      = (in_row != '0);
    info.last_row      = r_is_last;
    info.prev_col      = !col_first;
    info.last_col      = c_is_last;
    info.next_state[0] = life_rule(win_next, 1, 1);
    info.next_state[1] = life_rule(win_next, 2, 1);
    info.next_state[2] = life_rule(win_next, 1, 2);
    info.next_state[3] = life_rule(win_next, 2, 2);
  end

  assign load = accept && (info.prev_row || info.last_row) && (info.prev_col || info.last_col);

  lgs_release #(
    .AW(AW)
  ) u_release (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .info      (info),
    .row       (in_row),
    .col       (in_col),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .next_alive(next_alive),
    .out_row   (out_row),
    .out_col   (out_col),
    .frame_last(frame_last),
    .run_last  (run_last)
  );

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (in_row <= last_idx) && (in_col <= last_idx))
    else $error("input position beyond grid");

  a_frame_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |->
      run_last && (out_row == 8'(last_idx)) && (out_col == 8'(last_idx)))
    else $error("frame_last away from the final cell");

  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    accept && col_first |=> (col_q[0] == 3'b000) && (col_q[1] == 3'b000))
    else $error("window not cleared at row start");
`endif

endmodule
